### design/hnrt_pkg.sv
// ----------------------------------------------------------------------------
// hnrt_pkg: shared definitions for the hashed name registry table
// Holds the result status codes, the packed bus widths and the step table
// of the shared hash arithmetic unit.
// ----------------------------------------------------------------------------
package hnrt_pkg;

  localparam int unsigned HNRT_ENTRIES_DEF = 64;

  // Packed widths of the request and result buses.
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Steps of the shared add / xor-shift unit: three per name byte, three
  // more to finalize the hash on the last byte.
  typedef enum logic [2:0] {
    MS_ADD_BYTE = 3'd0,
    MS_SHL10    = 3'd1,
    MS_SHR6     = 3'd2,
    MS_FIN3     = 3'd3,
    MS_FIN11    = 3'd4,
    MS_FIN15    = 3'd5
  } mix_step_t;

  typedef struct packed {
    logic       is_add;
    logic       use_byte;
    logic       shift_left;
    logic [3:0] shamt;
  } mix_op_t;

  function automatic mix_op_t mix_op(input mix_step_t step);
    mix_op_t op;
    op = '{is_add: 1'b1, use_byte: 1'b0, shift_left: 1'b1, shamt: 4'd0};
    case (step)
      MS_ADD_BYTE: op = '{is_add: 1'b1, use_byte: 1'b1, shift_left: 1'b1, shamt: 4'd0};
      MS_SHL10:    op = '{is_add: 1'b1, use_byte: 1'b0, shift_left: 1'b1, shamt: 4'd10};
      MS_SHR6:     op = '{is_add: 1'b0, use_byte: 1'b0, shift_left: 1'b0, shamt: 4'd6};
      MS_FIN3:     op = '{is_add: 1'b1, use_byte: 1'b0, shift_left: 1'b1, shamt: 4'd3};
      MS_FIN11:    op = '{is_add: 1'b0, use_byte: 1'b0, shift_left: 1'b0, shamt: 4'd11};
      MS_FIN15:    op = '{is_add: 1'b1, use_byte: 1'b0, shift_left: 1'b1, shamt: 4'd15};
      default:     op = '{is_add: 1'b1, use_byte: 1'b0, shift_left: 1'b1, shamt: 4'd0};
    endcase
    return op;
  endfunction

endpackage

### design/hnrt_ram.sv
// ----------------------------------------------------------------------------
// hnrt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hnrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### design/hashed_name_registry_table_top.sv
// ----------------------------------------------------------------------------
// hashed_name_registry_table_top: name registry keyed by a one-at-a-time hash
// Hashes streamed name bytes, inserts the final hash with its handle, and
// answers lookups by hash with the stored handle.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Ports                   Contents
// in_*      in   tvalid tready tdata     name_byte [7:0], handle [39:8],
//                tlast tuser             lookup_hash [71:40]; tlast = last byte,
//                                        tuser = opcode (1 = lookup)
// out_*     out  tvalid tready tdata     status [1:0], found_handle [33:2],
//                                        computed_hash [65:34]
//
// A name byte that is not the last is taken from in_* and then passes
// through three steps of the shared add / xor-shift unit.
// A last byte adds three more unit steps to finalize the hash, a key scan
// through the key RAM at one entry per cycle (stopping early on a match),
// and the S_RESP state that loads the result register.
// A lookup is taken and then runs the same scan and S_RESP.
// Reset (rst_n low, synchronous) empties the table and clears the hash.
// The result register decouples the two sides: a new request is taken while
// an earlier result still waits on out_tready. A request that finishes while
// that result still waits holds in its last cycle, and no request is taken.
//
module hashed_name_registry_table_top
  #(
  parameter int unsigned TABLE_ENTRIES = hnrt_pkg::HNRT_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // name_byte [7:0], handle [39:8], lookup_hash [71:40]
  input  logic [hnrt_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tlast,
  // opcode: 0 = name byte, 1 = lookup
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status [1:0], found_handle [33:2], computed_hash [65:34], zero above
  output logic [hnrt_pkg::OUT_DATA_W-1:0] out_tdata
);

  import hnrt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  // The fill count has to hold TABLE_ENTRIES itself.
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t    state_r, state_nxt;
  mix_step_t step_r, step_nxt;

  logic [31:0] acc_r, acc_nxt;          // running hash of the name in progress
  logic [31:0] key_r, key_nxt;          // key being searched or inserted
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] handle_r, handle_nxt;
  logic        last_r, last_nxt;
  logic        lookup_r, lookup_nxt;

  // Entries are only ever added, always at the lowest free slot, so the
  // valid entries are exactly slots 0 .. cnt_r-1 and a fill count stands in
  // for per-entry valid marks.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;        // next slot to read during a scan
  logic          pend_r, pend_nxt;      // a read issued last cycle is arriving

  status_t     res_status_r, res_status_nxt;
  logic [31:0] res_handle_r, res_handle_nxt;
  logic [31:0] res_hash_r, res_hash_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Shared arithmetic unit: acc + operand or acc ^ operand.
  mix_op_t     op;
  logic [31:0] operand;
  logic [31:0] unit_res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   key_rd;
  logic [31:0]   handle_rd;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign ram_waddr  = cnt_r[AW-1:0];

  always_comb begin
    op = mix_op(step_r);
    if (op.use_byte) begin
      operand = {24'd0, byte_r};
    end else if (op.shift_left) begin
      operand = acc_r << op.shamt;
    end else begin
      operand = acc_r >> op.shamt;
    end
    unit_res = op.is_add ? (acc_r + operand) : (acc_r ^ operand);
  end

  hnrt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (key_r),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (key_rd)
  );

  hnrt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_handle_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (handle_r),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (handle_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    key_nxt        = key_r;
    byte_nxt       = byte_r;
    handle_nxt     = handle_r;
    last_nxt       = last_r;
    lookup_nxt     = lookup_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_hash_nxt   = res_hash_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            key_nxt    = in_tdata[71:40];
            lookup_nxt = 1'b1;
            idx_nxt    = '0;
            pend_nxt   = 1'b0;
            state_nxt  = S_SCAN;
          end else begin
            byte_nxt   = in_tdata[7:0];
            handle_nxt = in_tdata[39:8];
            last_nxt   = in_tlast;
            lookup_nxt = 1'b0;
            step_nxt   = MS_ADD_BYTE;
            state_nxt  = S_MIX;
          end
        end
      end

      S_MIX: begin
        acc_nxt = unit_res;
        case (step_r)
          MS_ADD_BYTE: step_nxt = MS_SHL10;
          MS_SHL10:    step_nxt = MS_SHR6;
          MS_SHR6: begin
            if (last_r) begin
              step_nxt = MS_FIN3;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          MS_FIN3:     step_nxt = MS_FIN11;
          MS_FIN11:    step_nxt = MS_FIN15;
          MS_FIN15: begin
            // The name is complete: its hash becomes the key and the
            // accumulator starts over for the next name.
            key_nxt   = unit_res;
            acc_nxt   = '0;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
          default:     state_nxt = S_IDLE;
        endcase
      end

      S_SCAN: begin
        if (pend_r && (key_rd == key_r)) begin
          // Key present: a lookup hits, an insert is a duplicate.
          if (lookup_r) begin
            res_status_nxt = ST_OK;
            res_handle_nxt = handle_rd;
            res_hash_nxt   = '0;
          end else begin
            res_status_nxt = ST_MISS;
            res_handle_nxt = '0;
            res_hash_nxt   = key_r;
          end
          state_nxt = S_RESP;
        end else if (!pend_r && (idx_r == cnt_r)) begin
          // Every valid entry compared without a match.
          res_handle_nxt = '0;
          if (lookup_r) begin
            res_status_nxt = ST_MISS;
            res_hash_nxt   = '0;
          end else begin
            res_hash_nxt = key_r;
            if (cnt_r == CW'(TABLE_ENTRIES)) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we         = 1'b1;
              cnt_nxt        = cnt_r + CW'(1);
              res_status_nxt = ST_OK;
            end
          end
          state_nxt = S_RESP;
        end else if (idx_r != cnt_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{(OUT_DATA_W - 66){1'b0}}, res_hash_r, res_handle_r, res_status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= MS_ADD_BYTE;
      acc_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    byte_r       <= byte_nxt;
    handle_r     <= handle_nxt;
    last_r       <= last_nxt;
    lookup_r     <= lookup_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_hash_r   <= res_hash_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

### design/hnrt_checker.sv
// ----------------------------------------------------------------------------
// hnrt_checker: port-level checks for the hashed name registry table
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hnrt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hnrt_pkg::OUT_DATA_W-1:0] out_tdata
);

  import hnrt_pkg::*;

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every request moves the sequencer out of S_IDLE, so the block is busy next.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken on consecutive cycles");

  // Only a request with status OK may carry a handle.
  a_handle_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> out_tdata[33:2] == 32'd0)
    else $error("handle reported on a failed request");

  // Registration results carry a hash and never a handle.
  a_hash_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[65:34] != 32'd0) |-> out_tdata[33:2] == 32'd0)
    else $error("result carries both a hash and a handle");

endmodule

bind hashed_name_registry_table_top hnrt_checker u_hnrt_checker (.*);

### verif/tb_hashed_name_registry_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_name_registry_table_top: regression for the hashed name registry
// Streams name registrations and hash lookups into the table. A scoreboard
// object keeps its own copy of the hash accumulator and of the key / handle
// table, predicts every reply, and checks each reply the block sends back.
// ----------------------------------------------------------------------------
module tb_hashed_name_registry_table_top;
  import hnrt_pkg::*;

  localparam int unsigned TABLE_SIZE  = HNRT_ENTRIES_DEF;
  // Number of requests after which the random part stops.
  localparam int          TARGET_REQS = 420;
  // Cycles without any handshake before the run is abandoned. The longest
  // correct quiet stretch is the long receiver hold-off plus one full scan.
  localparam int          IDLE_LIMIT  = 5000;
  // A last byte on a full table compares every entry before it replies.
  localparam int          DRAIN_CYCLES = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // name_byte [7:0], handle [39:8], lookup_hash [71:40]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  // opcode: 0 = name byte, 1 = lookup
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // status [1:0], found_handle [33:2], computed_hash [65:34], zero above
  logic [OUT_DATA_W-1:0] out_tdata;

  // One predicted reply of the table.
  typedef struct {
    status_t     status;
    logic [31:0] found_handle;
    logic [31:0] computed_hash;
  } reply_t;

  // The scoreboard holds a private model of the registry. Every accepted
  // request is folded into it, and any reply it implies is queued so that
  // replies coming out of the block can be compared in order.
  class registry_scoreboard;
    logic [31:0] accum;
    bit          slot_used [TABLE_SIZE];
    logic [31:0] slot_key [TABLE_SIZE];
    logic [31:0] slot_handle [TABLE_SIZE];
    reply_t      pending_replies [$];
    int          errors;
    int          checked;
    int          n_stored, n_dup, n_full, n_hit, n_miss;

    function new();
      accum = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
      checked = 0;
      n_stored = 0;
      n_dup = 0;
      n_full = 0;
      n_hit = 0;
      n_miss = 0;
    endfunction

    function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
      h = h + {24'd0, b};
      h = h + (h << 10);
      h = h ^ (h >> 6);
      return h;
    endfunction

    function logic [31:0] seal_hash(logic [31:0] h);
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
    endfunction

    function int find_key(logic [31:0] key);
      for (int i = 0; i < TABLE_SIZE; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < TABLE_SIZE; i++)
        if (!slot_used[i]) return i;
      return -1;
    endfunction

    // A key that is stored right now, or a random one while the table is empty.
    function logic [31:0] stored_key();
      int live [$];
      for (int i = 0; i < TABLE_SIZE; i++)
        if (slot_used[i]) live.push_back(i);
      if (live.size() == 0) return $urandom;
      return slot_key[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task note_request(logic lookup, logic [7:0] nb, logic lst, logic [31:0] hd,
                      logic [31:0] qh);
      reply_t      r;
      int          hit;
      int          slot;
      logic [31:0] key;
      if (lookup) begin
        // A lookup leaves any name in progress untouched.
        hit = find_key(qh);
        r.computed_hash = '0;
        if (hit >= 0) begin
          r.status = ST_OK;
          r.found_handle = slot_handle[hit];
          n_hit++;
        end else begin
          r.status = ST_MISS;
          r.found_handle = '0;
          n_miss++;
        end
        pending_replies.push_back(r);
        return;
      end
      accum = fold_byte(accum, nb);
      if (!lst) return;
      key = seal_hash(accum);
      accum = '0;
      r.found_handle = '0;
      r.computed_hash = key;
      // The duplicate test wins over the full test.
      if (find_key(key) >= 0) begin
        r.status = ST_MISS;
        n_dup++;
      end else begin
        slot = free_slot();
        if (slot < 0) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          slot_used[slot] = 1'b1;
          slot_key[slot] = key;
          slot_handle[slot] = hd;
          r.status = ST_OK;
          n_stored++;
        end
      end
      pending_replies.push_back(r);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      reply_t want;
      checked++;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %0d arrived with nothing expected, data %h",
                                  checked, data));
        return;
      end
      want = pending_replies.pop_front();
      if (data[1:0] !== want.status)
        report_mismatch($sformatf("reply %0d status got %0d want %0d",
                                  checked, data[1:0], want.status));
      if (data[33:2] !== want.found_handle)
        report_mismatch($sformatf("reply %0d found_handle got %h want %h",
                                  checked, data[33:2], want.found_handle));
      if (data[65:34] !== want.computed_hash)
        report_mismatch($sformatf("reply %0d computed_hash got %h want %h",
                                  checked, data[65:34], want.computed_hash));
    endtask
  endclass

  registry_scoreboard sb;
  int                 reqs_sent;
  int                 burst_left;
  int                 idle_cycles = 0;
  logic [63:0]        bank_text [$];
  int                 bank_len [$];

  hashed_name_registry_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock, low for the first half period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // After each accepted request the sender either keeps going within its
  // burst or drops valid for a random gap. Some bursts are long so that
  // back-to-back stretches occur as well.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 15);
    end
  endtask

  // Offers one request and waits until the block takes it. The request is
  // handed to the scoreboard at the edge where the handshake completes.
  task automatic offer_request(input logic lookup, input logic [7:0] nb,
                               input logic lst, input logic [31:0] hd,
                               input logic [31:0] qh);
    in_tvalid <= 1'b1;
    in_tuser  <= lookup;
    in_tlast  <= lst;
    in_tdata  <= {qh, hd, nb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(lookup, nb, lst, hd, qh);
    reqs_sent++;
    pace_sender();
  endtask

  // Streams a name of up to eight bytes, the first byte in the low bits of
  // text. The handle only matters on the last byte; the other bytes and the
  // unused lookup field carry random values. With peek_midway set, a lookup
  // of a stored key is slipped in between two bytes of the name.
  task automatic send_name(input logic [63:0] text, input int len,
                           input logic [31:0] hd, input bit peek_midway);
    for (int i = 0; i < len; i++) begin
      if (peek_midway && len > 1 && i == len / 2)
        offer_request(1'b1, 8'($urandom), 1'($urandom), $urandom,
                      sb.stored_key());
      offer_request(1'b0, text[8*i +: 8], (i == len - 1),
                    (i == len - 1) ? hd : 32'($urandom), $urandom);
    end
  endtask

  // Stops offering and waits until every predicted reply has come back.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: checks each reply taken, then decides readiness for the next
  // edge. Readiness follows phases of random length: always ready, a
  // rotating eight-bit pattern, or random stalls. Once 60 replies have been
  // checked it holds off for hold_left while the sender keeps offering, so
  // the result register fills and the block has to stall its input.
  initial begin : receiver
    int          mode;
    int          phase_left;
    int          hold_left;
    bit          hold_done;
    logic [7:0]  pat;
    mode = 0;
    phase_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    pat = 8'hff;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (!hold_done && sb.checked >= 60) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 2);
          pat = 8'($urandom);
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default: begin
            out_tready <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  // Watchdog: gives up when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("hashed_name_registry_table_top regression: fail");
      $finish;
    end
  end

  // Main stimulus: reset, a directed pass over the corner cases, then
  // random traffic to the request target, drained halfway, then the drain.
  initial begin : stimulus
    int          pick;
    int          len;
    int          idx;
    bit          paused;
    logic [63:0] text;
    sb = new();
    reqs_sent = 0;
    burst_left = 0;
    paused = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lookup on the empty table, with every ignored field set to all ones.
    offer_request(1'b1, 8'hff, 1'b1, 32'hffff_ffff, 32'h0000_0000);
    // Single-byte names at both byte extremes and both handle extremes.
    offer_request(1'b0, 8'h00, 1'b1, 32'h0000_0000, 32'hffff_ffff);
    offer_request(1'b0, 8'hff, 1'b1, 32'hffff_ffff, 32'h0000_0000);
    // A two-byte name with a lookup of the all-ones hash between its bytes.
    offer_request(1'b0, 8'h61, 1'b0, 32'h0, 32'hffff_ffff);
    offer_request(1'b1, 8'h00, 1'b0, 32'h0, 32'hffff_ffff);
    offer_request(1'b0, 8'h62, 1'b1, 32'hc0de_0001, 32'h0);
    // Registering the zero byte again must be refused as a duplicate.
    offer_request(1'b0, 8'h00, 1'b1, 32'h1234_5678, 32'h0);
    // Lookups that hit the names stored so far.
    offer_request(1'b1, 8'h00, 1'b0, 32'h0,
                  sb.seal_hash(sb.fold_byte(32'h0, 8'h00)));
    offer_request(1'b1, 8'h00, 1'b0, 32'h0,
                  sb.seal_hash(sb.fold_byte(32'h0, 8'hff)));
    offer_request(1'b1, 8'h00, 1'b0, 32'h0, sb.stored_key());
    // An eight-byte name, then a lookup of a stored key.
    send_name(64'h0123_4567_89ab_cdef, 8, 32'h5a5a_a5a5, 1'b0);
    offer_request(1'b1, 8'h00, 1'b0, 32'h0, sb.stored_key());
    drain_replies();

    while (reqs_sent < TARGET_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // Half the lookups aim at a stored key, the rest are random misses.
        offer_request(1'b1, 8'($urandom), 1'($urandom), $urandom,
                      ($urandom_range(0, 1) != 0) ? sb.stored_key() : 32'($urandom));
      end else if (pick < 40 && bank_text.size() != 0) begin
        // Repeat an earlier name: a duplicate if it was stored, also once the table is full.
        idx = $urandom_range(0, bank_text.size() - 1);
        send_name(bank_text[idx], bank_len[idx], $urandom, 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        len = (pick < 70) ? $urandom_range(1, 3) : (pick < 95) ? $urandom_range(4, 6) : 8;
        text = {32'($urandom), 32'($urandom)};
        bank_text.push_back(text);
        bank_len.push_back(len);
        send_name(text, len, $urandom, ($urandom_range(0, 9) == 0));
      end
      if (!paused && reqs_sent >= TARGET_REQS / 2) begin
        paused = 1'b1;
        drain_replies();
      end
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected replies never arrived", sb.pending()));

    $display("Covered %0d requests and %0d replies: %0d names stored, %0d duplicates,",
             reqs_sent, sb.checked, sb.n_stored, sb.n_dup);
    $display("%0d refused on a full table, %0d lookup hits, %0d lookup misses.",
             sb.n_full, sb.n_hit, sb.n_miss);
    if (sb.errors == 0) begin
      $display("hashed_name_registry_table_top regression: pass");
    end else begin
      $display("hashed_name_registry_table_top regression: fail");
    end
    $finish;
  end

endmodule
